// ===== hw/rtl/mvm_pkg.sv =====
// ----------------------------------------------------------------------------
// mvm_pkg
// shared types and constants of the streaming matrix-vector multiplier
// ----------------------------------------------------------------------------
package mvm_pkg;

    localparam int unsigned DEFAULT_MAX_LENGTH = 1024;
    localparam int unsigned ELEM_W             = 16;
    localparam int unsigned LEN_W              = 11;
    localparam int unsigned ROW_W              = 24;
    localparam int unsigned SUM_W              = 32;
    localparam int unsigned PROD_W             = 32;
    localparam int unsigned ACC_W              = 42;
    localparam int unsigned CFG_DATA_W         = 24;
    localparam int unsigned QUEUE_DEPTH        = 4;
    localparam int unsigned QUEUE_PTR_W        = 2;

    localparam logic [LEN_W-1:0] VECTOR_LENGTH_RESET = LEN_W'(8);
    localparam logic [ROW_W-1:0] ROW_COUNT_RESET     = ROW_W'(8);

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_MATRIX = 1'b1
    } op_t;

    typedef enum logic {
        REG_VECTOR_LENGTH = 1'b0,
        REG_ROW_COUNT     = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        op_t                      op;
        logic signed [ELEM_W-1:0] element;
    } in_item_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] row_sum;
        logic [ROW_W-1:0]        row_number;
        logic                    last_row;
    } out_item_t;

    // one multiply-accumulate task handed from front to back
    typedef struct packed {
        logic signed [ELEM_W-1:0] element;
        logic signed [ELEM_W-1:0] entry;
        logic                     row_end;
        logic [ROW_W-1:0]         row_number;
        logic                     last_row;
    } mac_task_t;

endpackage

// ===== hw/rtl/matrix_vector_multiply_stream.sv =====
// ----------------------------------------------------------------------------
// matrix_vector_multiply_stream
// streaming dense integer matrix-vector product
// ----------------------------------------------------------------------------
// s_ items with op load fill the vector memory in order, wrapping after
// vector_length entries; items with op matrix carry matrix elements in
// row-major order. after the last column of each row one m_ item gives the
// saturated dot product, the row number and a final-row flag.
// cfg_ writes set vector_length (index 0) and row_count (index 1); write
// them only while the block is idle. cfg_ready is always high.
// throughput: one item per cycle while s_ready stays high, set by the single
// multiplier and the one-port vector memory. a row's last element passes
// from acceptance through the front stage (memory read at acceptance), the
// task queue, the product register and the result register, which drives m_valid.
// reset clears counters, accumulator and queue; vector memory contents are
// undefined until loaded. while m_valid is high and m_ready is low the result
// register holds, the back end stops, the four-entry task queue fills, and
// s_ready falls once the queue and the front stage are full.
// ----------------------------------------------------------------------------
module matrix_vector_multiply_stream import mvm_pkg::*; #(
    parameter int unsigned MAX_LENGTH = DEFAULT_MAX_LENGTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  cfg_reg_t              cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_item
);

    logic      front_valid;
    logic      front_ready;
    mac_task_t front_task;
    logic      back_valid;
    logic      back_ready;
    mac_task_t back_task;

    mvm_front #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .task_valid (front_valid),
        .task_ready (front_ready),
        .task_data  (front_task)
    );

    mvm_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_task),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_data   (back_task)
    );

    mvm_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .task_valid (back_valid),
        .task_ready (back_ready),
        .task_data  (back_task),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item)
    );

endmodule

// ===== hw/rtl/mvm_front.sv =====
// ----------------------------------------------------------------------------
// mvm_front
// configuration registers, position counters and vector memory; turns each
// matrix item into a multiply-accumulate task
// ----------------------------------------------------------------------------
module mvm_front import mvm_pkg::*; #(
    parameter int unsigned MAX_LENGTH = DEFAULT_MAX_LENGTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  cfg_reg_t              cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_item,
    output logic                  task_valid,
    input  logic                  task_ready,
    output mac_task_t             task_data
);

    localparam int unsigned ADDR_W = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
    localparam logic [LEN_W-1:0] CAP_LAST =
        (MAX_LENGTH > ((1 << LEN_W) - 1)) ? '1 : LEN_W'(MAX_LENGTH - 1);

    logic [LEN_W-1:0]  vector_length_reg;
    logic [ROW_W-1:0]  row_count_reg;
    logic [LEN_W-1:0]  load_pos_reg, load_pos_next;
    logic [LEN_W-1:0]  col_pos_reg, col_pos_next;
    logic [ROW_W-1:0]  row_pos_reg, row_pos_next;
    logic              stage_valid_reg, stage_valid_next;
    logic signed [ELEM_W-1:0] element_reg;
    logic signed [ELEM_W-1:0] entry_reg;
    logic              row_end_reg;
    logic [ROW_W-1:0]  row_number_reg;
    logic              last_row_reg;

    logic signed [ELEM_W-1:0] vector_mem [MAX_LENGTH];

    logic [LEN_W-1:0]  len_last;
    logic [ROW_W-1:0]  rows_last;
    logic              accept;
    logic              row_end;
    logic              last_row;

    assign cfg_ready = 1'b1;

    always_comb begin
        if (vector_length_reg == '0) begin
            len_last = '0;
        end else if ({{(32 - LEN_W){1'b0}}, vector_length_reg} > 32'(MAX_LENGTH)) begin
            len_last = CAP_LAST;
        end else begin
            len_last = vector_length_reg - LEN_W'(1);
        end
        rows_last = (row_count_reg == '0) ? '0 : row_count_reg - ROW_W'(1);
    end

    assign s_ready  = !stage_valid_reg || task_ready;
    assign accept   = s_valid && s_ready;
    assign row_end  = (col_pos_reg >= len_last);
    assign last_row = (row_pos_reg >= rows_last);

    always_comb begin
        load_pos_next    = load_pos_reg;
        col_pos_next     = col_pos_reg;
        row_pos_next     = row_pos_reg;
        stage_valid_next = stage_valid_reg && !task_ready;
        if (accept) begin
            unique case (s_item.op)
                OP_LOAD: begin
                    load_pos_next = (load_pos_reg >= len_last) ? '0
                                                               : load_pos_reg + LEN_W'(1);
                end
                OP_MATRIX: begin
                    stage_valid_next = 1'b1;
                    col_pos_next     = row_end ? '0 : col_pos_reg + LEN_W'(1);
                    if (row_end) begin
                        row_pos_next = last_row ? '0 : row_pos_reg + ROW_W'(1);
                    end
                end
                default: begin
                    stage_valid_next = stage_valid_reg && !task_ready;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vector_length_reg <= VECTOR_LENGTH_RESET;
            row_count_reg     <= ROW_COUNT_RESET;
            load_pos_reg      <= '0;
            col_pos_reg       <= '0;
            row_pos_reg       <= '0;
            stage_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_VECTOR_LENGTH: vector_length_reg <= cfg_data[LEN_W-1:0];
                    REG_ROW_COUNT:     row_count_reg     <= cfg_data[ROW_W-1:0];
                    default:           row_count_reg     <= row_count_reg;
                endcase
            end
            load_pos_reg    <= load_pos_next;
            col_pos_reg     <= col_pos_next;
            row_pos_reg     <= row_pos_next;
            stage_valid_reg <= stage_valid_next;
        end
    end

    // vector memory: write on load items, registered read on matrix items
    always_ff @(posedge aclk) begin
        if (accept && s_item.op == OP_LOAD) begin
            vector_mem[ADDR_W'(load_pos_reg)] <= s_item.element;
        end
        if (accept && s_item.op == OP_MATRIX) begin
            entry_reg      <= vector_mem[ADDR_W'(col_pos_reg)];
            element_reg    <= s_item.element;
            row_end_reg    <= row_end;
            row_number_reg <= row_pos_reg;
            last_row_reg   <= last_row;
        end
    end

    assign task_valid             = stage_valid_reg;
    assign task_data.element      = element_reg;
    assign task_data.entry        = entry_reg;
    assign task_data.row_end      = row_end_reg;
    assign task_data.row_number   = row_number_reg;
    assign task_data.last_row     = last_row_reg;

endmodule

// ===== hw/rtl/mvm_queue.sv =====
// ----------------------------------------------------------------------------
// mvm_queue
// short task queue between front and back
// ----------------------------------------------------------------------------
module mvm_queue import mvm_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push_valid,
    output logic      push_ready,
    input  mac_task_t push_data,
    output logic      pop_valid,
    input  logic      pop_ready,
    output mac_task_t pop_data
);

    localparam int unsigned CNT_W = QUEUE_PTR_W + 1;

    mac_task_t              slots_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   push;
    logic                   pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = slots_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QUEUE_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QUEUE_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hw/rtl/mvm_back.sv =====
// ----------------------------------------------------------------------------
// mvm_back
// multiply, row accumulation, saturation and result register
// ----------------------------------------------------------------------------
module mvm_back import mvm_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      task_valid,
    output logic      task_ready,
    input  mac_task_t task_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W - 1){1'b0}}};

    logic                     advance;
    logic                     mul_valid_reg, mul_valid_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     row_end_reg;
    logic [ROW_W-1:0]         row_number_reg;
    logic                     last_row_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic                     out_valid_reg, out_valid_next;
    out_item_t                out_reg;
    logic signed [ACC_W-1:0]  sum;
    logic signed [SUM_W-1:0]  sum_sat;

    assign advance    = !out_valid_reg || m_ready;
    assign task_ready = advance;

    assign sum = acc_reg + ACC_W'(prod_reg);

    always_comb begin
        if (sum[ACC_W-1:SUM_W-1] == '0 || sum[ACC_W-1:SUM_W-1] == '1) begin
            sum_sat = sum[SUM_W-1:0];
        end else begin
            sum_sat = sum[ACC_W-1] ? SUM_MIN : SUM_MAX;
        end
    end

    always_comb begin
        mul_valid_next = mul_valid_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && !m_ready;
        if (advance) begin
            mul_valid_next = task_valid;
            out_valid_next = mul_valid_reg && row_end_reg;
            if (mul_valid_reg) begin
                acc_next = row_end_reg ? '0 : sum;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            mul_valid_reg <= mul_valid_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && task_valid) begin
            prod_reg       <= task_data.element * task_data.entry;
            row_end_reg    <= task_data.row_end;
            row_number_reg <= task_data.row_number;
            last_row_reg   <= task_data.last_row;
        end
        if (advance && mul_valid_reg && row_end_reg) begin
            out_reg.row_sum    <= sum_sat;
            out_reg.row_number <= row_number_reg;
            out_reg.last_row   <= last_row_reg;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;

endmodule
